FILE: design/pmrc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmrc_pkg: shared types and constants of the rule classifier
// Item layouts, rule record, operation and status codes, sequencer states.
// ----------------------------------------------------------------------------
package pmrc_pkg;

    // default number of rule slots in the ring
    localparam int TABLE_DEPTH_DEF = 64;

    // operation codes
    typedef enum logic [1:0] {
        OP_LOOKUP = 2'd0,
        OP_INSERT = 2'd1,
        OP_REMOVE = 2'd2,
        OP_CLEAR  = 2'd3
    } t_op;

    // verdict returned when no rule hits, or for a non-lookup item
    localparam logic [1:0] DEC_DEFER = 2'd3;

    // status codes
    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_FULL      = 2'd1;
    localparam logic [1:0] STAT_NOT_FOUND = 2'd2;

    // input item
    typedef struct packed {
        t_op         op;
        logic [31:0] key;
        logic [31:0] rule_id;
        logic [31:0] rule_priority;
        logic [31:0] rule_mask;
        logic [31:0] rule_match;
        logic [1:0]  rule_action;
    } t_in_item;

    // result item
    typedef struct packed {
        logic [1:0]  decision;
        logic        hit;
        logic [31:0] hit_total;
        logic [1:0]  status;
    } t_out_item;

    // one stored rule
    typedef struct packed {
        logic [31:0] id;
        logic [31:0] prio;
        logic [31:0] mask;
        logic [31:0] match;
        logic [1:0]  action;
        logic [31:0] hits;
    } t_rule;

    // what the head logic reports for one ring step
    typedef struct packed {
        logic        event_hit;   // lookup hit, insert placed, or remove found
        logic [1:0]  decision;
        logic [31:0] hit_total;
    } t_step;

    // sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH
    } t_state;

endpackage

FILE: design/pmrc_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmrc_if: item channels of the rule classifier
// Valid/ready channels carrying input items and result items.
// ----------------------------------------------------------------------------
interface pmrc_in_if;
    import pmrc_pkg::*;

    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface pmrc_out_if;
    import pmrc_pkg::*;

    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: design/priority_masked_rule_classifier_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// priority_masked_rule_classifier_unit: priority ordered masked rule table
// Rules sit in a ring of TABLE_DEPTH slots, sorted by ascending priority value.
// Every item (lookup, insert, remove or clear) rotates the ring once, one slot
// per cycle, while the head logic edits the rule stream as it passes: a lookup
// counts the first masked match, an insert drops the new rule in after all
// rules of equal priority, a remove pulls later rules up over the removed one.
// Each item is accepted in S_IDLE, rotated through S_SCAN and finished in
// S_FINISH, which waits until the output register is free and then loads the
// result there, so the next item may be taken while that result waits. The
// table needs no initialization after reset.
// ----------------------------------------------------------------------------
module priority_masked_rule_classifier_unit #(
    parameter int TABLE_DEPTH = pmrc_pkg::TABLE_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    pmrc_in_if.sink    i_item,
    pmrc_out_if.source o_result
);
    import pmrc_pkg::*;

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam logic [IDX_W-1:0] LAST_STEP = IDX_W'(TABLE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(TABLE_DEPTH);

    t_state           r_state;
    t_state           n_state;
    t_in_item         r_req;
    logic [IDX_W-1:0] r_step;
    logic [CNT_W-1:0] r_count;
    logic             r_done;
    t_rule            r_carry;
    logic [1:0]       r_decision;
    logic [31:0]      r_hit_total;
    t_out_item        r_out;
    logic             r_out_valid;

    logic      w_accept;
    logic      w_shift;
    logic      w_out_load;
    logic      w_full;
    t_rule     w_wr;
    t_step     w_step;
    t_out_item w_result;
    t_rule     w_cell [TABLE_DEPTH];

    assign w_full = (r_count == FULL_CNT);

    // ring of rule slots, head at slot 0, tail fed by the head logic
    for (genvar j = 0; j < TABLE_DEPTH; j++) begin : g_cell
        t_rule w_next;
        if (j == TABLE_DEPTH - 1) begin : g_tail
            assign w_next = w_wr;
        end else begin : g_mid
            assign w_next = w_cell[j+1];
        end
        pmrc_cell u_cell (
            .i_clk   (i_clk),
            .i_shift (w_shift),
            .i_next  (w_next),
            .o_rule  (w_cell[j])
        );
    end

    pmrc_head #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_head (
        .i_req    (r_req),
        .i_step   (r_step),
        .i_count  (r_count),
        .i_full   (w_full),
        .i_done   (r_done),
        .i_carry  (r_carry),
        .i_head   (w_cell[0]),
        .i_second (w_cell[1]),
        .o_wr     (w_wr),
        .o_step   (w_step)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (i_item.valid)         n_state = S_SCAN;
            S_SCAN:   if (r_step == LAST_STEP)  n_state = S_FINISH;
            S_FINISH: if (w_out_load)           n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        i_item.ready = (r_state == S_IDLE);
        w_shift      = (r_state == S_SCAN);
        w_out_load   = (r_state == S_FINISH) && (!r_out_valid || o_result.ready);
    end

    assign w_accept = i_item.valid && i_item.ready;

    // result assembly
    always_comb begin
        w_result.decision  = DEC_DEFER;
        w_result.hit       = 1'b0;
        w_result.hit_total = 32'd0;
        w_result.status    = STAT_OK;
        unique case (r_req.op)
            OP_LOOKUP: begin
                if (r_done) begin
                    w_result.decision  = r_decision;
                    w_result.hit       = 1'b1;
                    w_result.hit_total = r_hit_total;
                end
            end
            OP_INSERT: if (w_full)  w_result.status = STAT_FULL;
            OP_REMOVE: if (!r_done) w_result.status = STAT_NOT_FOUND;
            OP_CLEAR:  w_result.status = STAT_OK;
            default:   w_result.status = STAT_OK;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_count     <= '0;
            r_done      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_accept) begin
                r_step <= '0;
                r_done <= 1'b0;
            end else if (w_shift) begin
                r_step <= r_step + 1'b1;
                if (w_step.event_hit) begin
                    r_done <= 1'b1;
                end
            end
            // rule count changes once the rotation is over
            if (w_out_load) begin
                unique case (r_req.op)
                    OP_INSERT: if (!w_full) r_count <= r_count + 1'b1;
                    OP_REMOVE: if (r_done)  r_count <= r_count - 1'b1;
                    OP_CLEAR:  r_count <= '0;
                    default:   r_count <= r_count;
                endcase
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req <= i_item.data;
        end
        if (w_shift) begin
            r_carry <= w_cell[0];
            if (w_step.event_hit) begin
                r_decision  <= w_step.decision;
                r_hit_total <= w_step.hit_total;
            end
        end
        if (w_out_load) begin
            r_out <= w_result;
        end
    end

    assign o_result.valid = r_out_valid;
    assign o_result.data  = r_out;

endmodule

FILE: design/pmrc_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmrc_cell: one rule slot of the ring
// Holds one rule and takes its neighbor's rule on every shift cycle.
// ----------------------------------------------------------------------------
module pmrc_cell (
    input  logic            i_clk,
    input  logic            i_shift,
    input  pmrc_pkg::t_rule i_next,
    output pmrc_pkg::t_rule o_rule
);
    import pmrc_pkg::*;

    t_rule r_rule;

    // slot register, payload only
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_rule <= i_next;
        end
    end

    assign o_rule = r_rule;

endmodule

FILE: design/pmrc_head.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmrc_head: step logic at the head of the ring
// Looks at the rule leaving the head slot and decides what re-enters the tail.
// ----------------------------------------------------------------------------
module pmrc_head #(
    parameter int TABLE_DEPTH = pmrc_pkg::TABLE_DEPTH_DEF,
    localparam int IDX_W = $clog2(TABLE_DEPTH),
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1)
) (
    input  pmrc_pkg::t_in_item i_req,
    input  logic [IDX_W-1:0]   i_step,
    input  logic [CNT_W-1:0]   i_count,
    input  logic               i_full,
    input  logic               i_done,
    input  pmrc_pkg::t_rule    i_carry,
    input  pmrc_pkg::t_rule    i_head,
    input  pmrc_pkg::t_rule    i_second,
    output pmrc_pkg::t_rule    o_wr,
    output pmrc_pkg::t_step    o_step
);
    import pmrc_pkg::*;

    logic        w_in_range;
    logic        w_match;
    logic        w_place;
    logic        w_found;
    logic [31:0] w_hits_inc;
    t_rule       w_new_rule;

    // slot at the head holds a live rule
    assign w_in_range = CNT_W'(i_step) < i_count;
    assign w_hits_inc = i_head.hits + 32'd1;

    assign w_match = !i_done && w_in_range
                     && ((i_req.key & i_head.mask) == i_head.match);
    // insert goes before the first rule of strictly larger priority value
    assign w_place = !i_done && !i_full
                     && (!w_in_range || (i_head.prio > i_req.rule_priority));
    assign w_found = !i_done && w_in_range && (i_head.id == i_req.rule_id);

    always_comb begin
        w_new_rule        = '0;
        w_new_rule.id     = i_req.rule_id;
        w_new_rule.prio   = i_req.rule_priority;
        w_new_rule.mask   = i_req.rule_mask;
        w_new_rule.match  = i_req.rule_match;
        w_new_rule.action = i_req.rule_action;
        w_new_rule.hits   = 32'd0;
    end

    // tail write and step report
    always_comb begin
        o_wr             = i_head;
        o_step.event_hit = 1'b0;
        o_step.decision  = i_head.action;
        o_step.hit_total = w_hits_inc;
        unique case (i_req.op)
            OP_LOOKUP: begin
                o_step.event_hit = w_match;
                if (w_match) begin
                    o_wr.hits = w_hits_inc;
                end
            end
            OP_INSERT: begin
                o_step.event_hit = w_place;
                if (w_place) begin
                    o_wr = w_new_rule;
                end else if (i_done) begin
                    // rules after the insert point move down one slot
                    o_wr = i_carry;
                end
            end
            OP_REMOVE: begin
                o_step.event_hit = w_found;
                // from the removed rule on, every slot takes its successor
                if (i_done || w_found) begin
                    o_wr = i_second;
                end
            end
            OP_CLEAR: begin
                o_wr = i_head;
            end
            default: begin
                o_wr = i_head;
            end
        endcase
    end

endmodule

FILE: design/pmrc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmrc_checker: port level checks of the rule classifier
// Watches the item channels of the top level; attached by bind.
// ----------------------------------------------------------------------------
module pmrc_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                i_in_ready,
    input logic                i_out_valid,
    input logic                i_out_ready,
    input pmrc_pkg::t_out_item i_out_data
);
    import pmrc_pkg::*;

    // a waiting result holds still until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data))
        else $error("result item changed while stalled");

    // one item at a time: no second accept right after an accept
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input taken during a rotation");

    // a miss or a table command carries defer and a zero hit count
    a_miss_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_data.hit |->
            i_out_data.decision == DEC_DEFER && i_out_data.hit_total == 32'd0)
        else $error("miss result with verdict or hit count");

    // a hit comes only from a lookup, which always reports ok
    a_hit_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_data.hit |-> i_out_data.status == STAT_OK)
        else $error("hit result with non-ok status");

endmodule

bind priority_masked_rule_classifier_unit pmrc_checker u_pmrc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_item.valid),
    .i_in_ready  (i_item.ready),
    .i_out_valid (o_result.valid),
    .i_out_ready (o_result.ready),
    .i_out_data  (o_result.data)
);
